// File: hw/rtl/wsls_pkg.sv
// ----------------------------------------------------------------------------
// wsls_pkg: shared constants and types for the word stack letter sorter
// Sizes of the word store, derived widths and the sort chain control bundle.
// ----------------------------------------------------------------------------
package wsls_pkg;

  localparam int MAX_WORD_LEN = 30;
  localparam int STACK_DEPTH  = 64;

  // word length 0..MAX_WORD_LEN
  localparam int LEN_W  = (MAX_WORD_LEN > 0) ? $clog2(MAX_WORD_LEN + 1) : 1;
  // stack count 0..STACK_DEPTH
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  // stack slot index
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  // flat character store
  localparam int CHARS  = STACK_DEPTH * MAX_WORD_LEN;
  localparam int CA_W   = (CHARS > 1) ? $clog2(CHARS) : 1;
  // threshold register and length compare width
  localparam int THR_W  = 4;
  localparam int CMP_W  = (LEN_W > THR_W) ? LEN_W : THR_W;
  localparam int CHAR_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

  // request kinds as carried on in_tuser
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // output tuser bit positions
  localparam int UB_EMPTY  = 0;
  localparam int UB_SORTED = 1;
  localparam int UB_DROP   = 2;
  localparam int USER_W    = 3;

  typedef struct packed {
    logic clear;  // empty every cell
    logic shift;  // move contents one cell toward the head
    logic sort;   // keep the smaller byte, pass the larger one on
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_FEED,
    ST_SETTLE,
    ST_DRAIN
  } state_t;

endpackage

// File: hw/rtl/wsls_cell.sv
// ----------------------------------------------------------------------------
// wsls_cell: one cell of the letter chain
// Holds one byte; keeps or passes incoming bytes, shifts toward the head.
// ----------------------------------------------------------------------------
module wsls_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsls_pkg::cell_ctrl_t        ctrl,
  input  logic                        in_vld,
  input  logic [wsls_pkg::CHAR_W-1:0] in_val,
  input  logic                        nb_full,
  input  logic [wsls_pkg::CHAR_W-1:0] nb_val,
  output logic                        full,
  output logic [wsls_pkg::CHAR_W-1:0] val,
  output logic                        pass_vld,
  output logic [wsls_pkg::CHAR_W-1:0] pass_val
);

  logic                        full_r, full_nxt;
  logic [wsls_pkg::CHAR_W-1:0] val_r, val_nxt;
  logic                        pvld_r, pvld_nxt;
  logic [wsls_pkg::CHAR_W-1:0] pval_r, pval_nxt;

  always_comb begin
    full_nxt = full_r;
    val_nxt  = val_r;
    pvld_nxt = 1'b0;
    pval_nxt = pval_r;
    if (ctrl.clear) begin
      full_nxt = 1'b0;
    end else if (ctrl.shift) begin
      full_nxt = nb_full;
      val_nxt  = nb_val;
    end else if (in_vld) begin
      if (!full_r) begin
        full_nxt = 1'b1;
        val_nxt  = in_val;
      end else if (ctrl.sort && (in_val < val_r)) begin
        // keep the smaller byte, push the held one onward
        val_nxt  = in_val;
        pvld_nxt = 1'b1;
        pval_nxt = val_r;
      end else begin
        pvld_nxt = 1'b1;
        pval_nxt = in_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      pvld_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
      pvld_r <= pvld_nxt;
    end
    val_r  <= val_nxt;
    pval_r <= pval_nxt;
  end

  assign full     = full_r;
  assign val      = val_r;
  assign pass_vld = pvld_r;
  assign pass_val = pval_r;

endmodule

// File: hw/rtl/wsls_chain.sv
// ----------------------------------------------------------------------------
// wsls_chain: row of letter cells
// Bytes enter at the head and travel along; the head cell is read on drain.
// ----------------------------------------------------------------------------
module wsls_chain (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wsls_pkg::cell_ctrl_t        ctrl,
  input  logic                        in_vld,
  input  logic [wsls_pkg::CHAR_W-1:0] in_val,
  output logic [wsls_pkg::CHAR_W-1:0] head_val
);

  localparam int N = wsls_pkg::MAX_WORD_LEN;

  logic                        full_w [N+1];
  logic [wsls_pkg::CHAR_W-1:0] val_w  [N+1];
  logic                        pvld_w [N+1];
  logic [wsls_pkg::CHAR_W-1:0] pval_w [N+1];

  // the slot past the tail reads as empty
  assign full_w[N] = 1'b0;
  assign val_w[N]  = '0;
  assign pvld_w[0] = in_vld;
  assign pval_w[0] = in_val;

  for (genvar k = 0; k < N; k++) begin : g_cell
    wsls_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .in_vld   (pvld_w[k]),
      .in_val   (pval_w[k]),
      .nb_full  (full_w[k+1]),
      .nb_val   (val_w[k+1]),
      .full     (full_w[k]),
      .val      (val_w[k]),
      .pass_vld (pvld_w[k+1]),
      .pass_val (pval_w[k+1])
    );
  end

  assign head_val = val_w[0];

endmodule

// File: hw/rtl/word_stack_letter_sort.sv
// ----------------------------------------------------------------------------
// word_stack_letter_sort: LIFO word stack with letter sort on pop
// Push requests deliver a word byte by byte; a pop request emits the top word,
// sorted ascending when its length reaches the configured threshold.
// ----------------------------------------------------------------------------
// Timing: a dropped byte or word and an empty pop show their single result
//   in the cycle after acceptance.
// A pop steps through the length read, the store reads, the settle phase,
//   the drain and the return to idle; the drain waits while the result is held.
// Throughput: one request at a time; the next is taken once the pop drains.
// Reset (synchronous, active low) empties the stack, sets the threshold to 5.
module word_stack_letter_sort (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: min_sort_length
  input  logic                          cfg_wen,
  input  logic [wsls_pkg::THR_W-1:0]    cfg_wdata,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wsls_pkg::CHAR_W-1:0]   in_tdata,   // [7:0] char_code
  input  logic                          in_tuser,   // [0] kind (1 = pop)
  input  logic                          in_tlast,   // last_char
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wsls_pkg::CHAR_W-1:0]   out_tdata,  // [7:0] char_out
  output logic [wsls_pkg::USER_W-1:0]   out_tuser,  // [0] stack_empty [1] was_sorted [2] dropped
  output logic                          out_tlast   // is_last
);

  localparam int LEN_W = wsls_pkg::LEN_W;
  localparam int CNT_W = wsls_pkg::CNT_W;
  localparam int SP_W  = wsls_pkg::SP_W;
  localparam int CA_W  = wsls_pkg::CA_W;
  localparam int CMP_W = wsls_pkg::CMP_W;
  localparam int CW    = wsls_pkg::CHAR_W;

  localparam logic [LEN_W-1:0] MAXL = LEN_W'(wsls_pkg::MAX_WORD_LEN);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(wsls_pkg::STACK_DEPTH);

  // storage
  logic [CW-1:0]    char_mem [wsls_pkg::CHARS];
  logic [LEN_W-1:0] len_mem  [wsls_pkg::STACK_DEPTH];
  logic [CW-1:0]    char_q_r;
  logic [LEN_W-1:0] len_q_r;

  // control state
  wsls_pkg::state_t             state_r, state_nxt;
  logic [wsls_pkg::THR_W-1:0]   thr_r;
  logic [CNT_W-1:0]             sc_r;
  logic [LEN_W-1:0]             bl_r;
  logic                         abandon_r;
  logic                         sorted_r;
  logic [LEN_W-1:0]             len_r;
  logic [CA_W-1:0]              base_r;
  logic [LEN_W-1:0]             rd_idx_r;
  logic [LEN_W:0]               settle_r;
  logic [LEN_W-1:0]             emit_r;
  logic                         feed_vld_r;

  // result register
  logic          out_valid_r;
  logic [CW-1:0] out_char_r;
  logic          out_last_r, out_empty_r, out_sorted_r, out_drop_r;

  // request decode
  logic             in_acc, out_free, is_push, is_pop;
  logic             stack_full, push_room, push_drop, char_we, len_we, pop_empty;
  logic [LEN_W-1:0] bl_after, len_eff;
  logic [CNT_W-1:0] sc_dec;
  logic [CA_W-1:0]  wr_addr, rd_addr;
  logic             char_re, emit, len_fail, eff_sorted;
  wsls_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]    head_val;

  assign out_free   = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign is_push    = in_acc && (in_tuser == wsls_pkg::KIND_PUSH);
  assign is_pop     = in_acc && (in_tuser == wsls_pkg::KIND_POP);
  assign stack_full = (sc_r == FULL);
  assign push_room  = (bl_r < MAXL);
  assign push_drop  = is_push && (stack_full || !push_room);
  assign bl_after   = push_room ? bl_r + LEN_W'(1) : bl_r;
  assign char_we    = is_push && !stack_full && push_room;
  assign len_we     = is_push && !stack_full && in_tlast;
  assign pop_empty  = is_pop && (sc_r == '0);
  assign sc_dec     = sc_r - CNT_W'(1);

  // flat address: slot * MAX_WORD_LEN + byte position
  assign wr_addr = CA_W'(sc_r[SP_W-1:0]) * CA_W'(wsls_pkg::MAX_WORD_LEN) + CA_W'(bl_r);
  assign rd_addr = base_r + CA_W'(rd_idx_r);

  // clamp the stored length to the word limit
  assign len_eff    = (len_q_r > MAXL) ? MAXL : len_q_r;
  assign eff_sorted = (CMP_W'(len_eff) >= CMP_W'(thr_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wsls_pkg::ST_IDLE: begin
        if (is_pop && (sc_r != '0)) state_nxt = wsls_pkg::ST_LEN;
      end
      wsls_pkg::ST_LEN: begin
        state_nxt = (len_eff == '0) ? wsls_pkg::ST_IDLE : wsls_pkg::ST_FEED;
      end
      wsls_pkg::ST_FEED: begin
        if (rd_idx_r == len_r - LEN_W'(1)) state_nxt = wsls_pkg::ST_SETTLE;
      end
      wsls_pkg::ST_SETTLE: begin
        if (settle_r == {1'b0, len_r} + (LEN_W+1)'(1)) state_nxt = wsls_pkg::ST_DRAIN;
      end
      wsls_pkg::ST_DRAIN: begin
        if (out_free && (emit_r == len_r - LEN_W'(1))) state_nxt = wsls_pkg::ST_IDLE;
      end
      default: state_nxt = wsls_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    char_re    = 1'b0;
    emit       = 1'b0;
    len_fail   = 1'b0;
    ctrl.clear = 1'b0;
    ctrl.shift = 1'b0;
    ctrl.sort  = sorted_r;
    case (state_r)
      wsls_pkg::ST_IDLE:   in_tready = out_free;
      wsls_pkg::ST_LEN: begin
        ctrl.clear = 1'b1;
        len_fail   = (len_eff == '0);
      end
      wsls_pkg::ST_FEED:   char_re = 1'b1;
      wsls_pkg::ST_SETTLE: ;
      wsls_pkg::ST_DRAIN: begin
        emit       = out_free;
        ctrl.shift = out_free;
      end
      default: ;
    endcase
  end

  // stores: write on push, registered reads
  always_ff @(posedge clk) begin
    if (char_we) char_mem[wr_addr] <= in_tdata;
    if (char_re) char_q_r <= char_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[sc_r[SP_W-1:0]] <= bl_after;
    if (is_pop) len_q_r <= len_mem[sc_dec[SP_W-1:0]];
  end

  // stack and word bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wsls_pkg::ST_IDLE;
      thr_r      <= wsls_pkg::THR_RESET;
      sc_r       <= '0;
      bl_r       <= '0;
      feed_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      feed_vld_r <= char_re;
      if (cfg_wen) thr_r <= cfg_wdata;
      if (is_push) begin
        if (stack_full) begin
          bl_r <= '0;
        end else if (in_tlast) begin
          sc_r <= sc_r + CNT_W'(1);
          bl_r <= '0;
        end else begin
          bl_r <= bl_after;
        end
      end else if (is_pop) begin
        bl_r <= '0;
        if (sc_r != '0) sc_r <= sc_dec;
      end
    end
  end

  // pop sequencing counters
  always_ff @(posedge clk) begin
    if (is_pop) begin
      abandon_r <= (bl_r != '0);
      base_r    <= CA_W'(sc_dec[SP_W-1:0]) * CA_W'(wsls_pkg::MAX_WORD_LEN);
    end
    case (state_r)
      wsls_pkg::ST_LEN: begin
        len_r    <= len_eff;
        sorted_r <= eff_sorted;
        rd_idx_r <= '0;
        settle_r <= '0;
      end
      wsls_pkg::ST_FEED:   rd_idx_r <= rd_idx_r + LEN_W'(1);
      wsls_pkg::ST_SETTLE: begin
        settle_r <= settle_r + (LEN_W+1)'(1);
        emit_r   <= '0;
      end
      wsls_pkg::ST_DRAIN:  if (emit) emit_r <= emit_r + LEN_W'(1);
      default: ;
    endcase
  end

  wsls_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_vld   (feed_vld_r),
    .in_val   (char_q_r),
    .head_val (head_val)
  );

  // result register: hold until taken, load one result at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_drop || pop_empty || len_fail || emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (push_drop) begin
      out_char_r   <= '0;
      out_last_r   <= 1'b1;
      out_empty_r  <= 1'b0;
      out_sorted_r <= 1'b0;
      out_drop_r   <= 1'b1;
    end else if (pop_empty) begin
      out_char_r   <= '0;
      out_last_r   <= 1'b1;
      out_empty_r  <= 1'b1;
      out_sorted_r <= 1'b0;
      out_drop_r   <= (bl_r != '0);
    end else if (len_fail) begin
      out_char_r   <= '0;
      out_last_r   <= 1'b1;
      out_empty_r  <= 1'b1;
      out_sorted_r <= 1'b0;
      out_drop_r   <= abandon_r;
    end else if (emit) begin
      out_char_r   <= head_val;
      out_last_r   <= (emit_r == len_r - LEN_W'(1));
      out_empty_r  <= 1'b0;
      out_sorted_r <= sorted_r;
      out_drop_r   <= abandon_r;
    end
  end

  assign out_tvalid                      = out_valid_r;
  assign out_tdata                       = out_char_r;
  assign out_tlast                       = out_last_r;
  assign out_tuser[wsls_pkg::UB_EMPTY]   = out_empty_r;
  assign out_tuser[wsls_pkg::UB_SORTED]  = out_sorted_r;
  assign out_tuser[wsls_pkg::UB_DROP]    = out_drop_r;

endmodule

// File: hw/rtl/wsls_checker.sv
// ----------------------------------------------------------------------------
// wsls_checker: port-level checks for the word stack letter sorter
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module wsls_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [wsls_pkg::CHAR_W-1:0]   out_tdata,
  input logic [wsls_pkg::USER_W-1:0]   out_tuser,
  input logic                          out_tlast
);

  logic                        mid_r;
  logic [wsls_pkg::CHAR_W-1:0] prev_r;
  logic                        out_acc;

  assign out_acc = out_tvalid && out_tready;

  // track the previous byte of a sorted word in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_acc) begin
      mid_r <= out_tuser[wsls_pkg::UB_SORTED] && !out_tlast;
    end
    if (out_acc) prev_r <= out_tdata;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[wsls_pkg::UB_EMPTY] |->
      out_tlast && (out_tdata == '0) && !out_tuser[wsls_pkg::UB_SORTED])
    else $error("empty pop result is not a lone zero result");

  a_sorted_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && mid_r |-> out_tuser[wsls_pkg::UB_SORTED] && (out_tdata >= prev_r))
    else $error("sorted word bytes out of ascending order");

  // the check does not cover the final byte of the word
  a_no_request_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
    mid_r && !out_tlast |-> !in_tready)
    else $error("request taken while a popped word is still draining");

endmodule

bind word_stack_letter_sort wsls_checker u_wsls_checker (.*);

// File: tb/sv/tb_word_stack_letter_sort.sv
// ----------------------------------------------------------------------------
// tb_word_stack_letter_sort: self-checking bench for the word stack sorter
// Drives push and pop requests with random gaps on both sides of the stream,
// predicts results with a behavioral copy of the stack or takes them typed in a
// directed table, and compares each accepted result field by field, across several sort thresholds.
// ----------------------------------------------------------------------------
module tb_word_stack_letter_sort;

  localparam int CW   = wsls_pkg::CHAR_W;
  localparam int TW   = wsls_pkg::THR_W;
  localparam int UW   = wsls_pkg::USER_W;
  localparam int MAXW = wsls_pkg::MAX_WORD_LEN;
  localparam int DEP  = wsls_pkg::STACK_DEPTH;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 50;    // random requests per threshold setting
  localparam int SETTLE_CYC   = 8;     // quiet time before a register write
  localparam int TAIL_CYC     = 120;   // watch time for stray results after the drain
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] code;
    logic          last;
  } req_t;

  typedef struct packed {
    logic [CW-1:0] ch;
    logic          last;
    logic          empty;
    logic          sorted;
    logic          drop;
  } res_t;

  typedef struct packed {
    req_t req;
    logic typed;   // expectation typed into the table instead of predicted
    res_t res;
  } dir_row_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_wen;
  logic [TW-1:0] cfg_wdata;
  logic          in_tvalid;
  logic          in_tready;
  logic [CW-1:0] in_tdata;
  logic          in_tuser;
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [CW-1:0] out_tdata;
  logic [UW-1:0] out_tuser;
  logic          out_tlast;

  word_stack_letter_sort u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the stack: stored words, their lengths, the word being
  // built and the sort threshold.
  // --------------------------------------------------------------------------
  logic [CW-1:0]     word_store [DEP][MAXW];
  int unsigned       word_len_store [DEP];
  int unsigned       depth_cnt;
  int unsigned       build_len;
  logic [TW-1:0]     sort_min;

  res_t step_out [MAXW];           // results caused by the latest request
  res_t expected_chars [$];        // results still to come, oldest first
  dir_row_t directed_rows [$];

  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int mismatches;
  int stall_cnt;

  function automatic res_t mk_res(logic [CW-1:0] c, logic l, logic e, logic s,
                                  logic d);
    return {c, l, e, s, d};
  endfunction

  // Apply one request to the stack copy; fill step_out and return the count.
  function automatic int word_stack_step(input req_t r);
    logic [CW-1:0]     letters [MAXW];
    logic [CW-1:0]     v;
    int unsigned       n;
    int unsigned       i;
    int unsigned       j;
    logic              lost;
    logic              aband;
    logic              srt;
    lost = 1'b0;
    if (r.kind == wsls_pkg::KIND_PUSH) begin
      if (depth_cnt >= DEP) begin
        // full stack: drop the byte and forget the word in progress
        lost = 1'b1;
        build_len = 0;
      end else begin
        if (build_len < MAXW) begin
          word_store[depth_cnt][build_len] = r.code;
          build_len++;
        end else begin
          lost = 1'b1;   // word truncated at the limit
        end
        if (r.last) begin
          word_len_store[depth_cnt] = build_len;
          depth_cnt++;
          build_len = 0;
        end
      end
      if (lost) begin
        step_out[0] = mk_res('0, 1'b1, 1'b0, 1'b0, 1'b1);
        return 1;
      end
      return 0;
    end
    // pop: abandon any partial word
    aband = (build_len != 0);
    build_len = 0;
    if (depth_cnt == 0) begin
      step_out[0] = mk_res('0, 1'b1, 1'b1, 1'b0, aband);
      return 1;
    end
    depth_cnt--;
    n = word_len_store[depth_cnt];
    if (n > MAXW) n = MAXW;
    if (n == 0) begin
      step_out[0] = mk_res('0, 1'b1, 1'b1, 1'b0, aband);
      return 1;
    end
    for (i = 0; i < n; i++) letters[i] = word_store[depth_cnt][i];
    srt = (n >= sort_min);
    if (srt) begin
      for (i = 1; i < n; i++) begin
        v = letters[i];
        j = i;
        while (j > 0 && letters[j-1] > v) begin
          letters[j] = letters[j-1];
          j--;
        end
        letters[j] = v;
      end
    end
    for (i = 0; i < n; i++) step_out[i] = mk_res(letters[i], i + 1 == n, 1'b0, srt, aband);
    return int'(n);
  endfunction

  function automatic void add_row(logic kind, logic [CW-1:0] code, logic last,
                                  logic typed, res_t res);
    directed_rows.push_back({kind, code, last, typed, res});
  endfunction

  // Offer one request, hold it until accepted, then queue what it causes.
  task automatic send_request(input req_t r, input logic typed, input res_t typed_res);
    int n;
    int i;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= r.code;
    in_tlast  <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n = word_stack_step(r);
    if (typed) expected_chars.push_back(typed_res);
    else for (i = 0; i < n; i++) expected_chars.push_back(step_out[i]);
    requests_sent++;
  endtask

  task automatic push_byte(input logic [CW-1:0] code, input logic last);
    send_request({wsls_pkg::KIND_PUSH, code, last}, 1'b0, '0);
  endtask

  task automatic pop_word();
    send_request({wsls_pkg::KIND_POP, CW'($urandom_range(255)), 1'($urandom_range(1))},
                 1'b0, '0);
  endtask

  task automatic send_word(input int len);
    int k;
    for (k = 0; k < len; k++) push_byte(CW'($urandom_range(255)), k == len - 1);
  endtask

  // Drop valid and let the block finish before touching the register.
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock, receiver stalls, result check and watchdog
  // --------------------------------------------------------------------------
  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: char_out=%0h tuser=%0b tlast=%0b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, out_tlast);
          mismatches++;
        end
        if (out_tuser[wsls_pkg::UB_EMPTY] !== want.empty) begin
          $error("stack_empty: expected %0b, got %0b", want.empty,
                 out_tuser[wsls_pkg::UB_EMPTY]);
          mismatches++;
        end
        if (out_tuser[wsls_pkg::UB_SORTED] !== want.sorted) begin
          $error("was_sorted: expected %0b, got %0b", want.sorted,
                 out_tuser[wsls_pkg::UB_SORTED]);
          mismatches++;
        end
        if (out_tuser[wsls_pkg::UB_DROP] !== want.drop) begin
          $error("dropped: expected %0b, got %0b", want.drop,
                 out_tuser[wsls_pkg::UB_DROP]);
          mismatches++;
        end
      end
    end
  end

  // Reset the count on any handshake; give up after a long silence.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb_word_stack_letter_sort failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [TW-1:0] thr_plan [PHASES];
    int p;
    int i;
    int pick;
    int wlen;
    int goal;
    thr_plan = '{4'd15, 4'd0, 4'd3, 4'd10, 4'd5, 4'd5};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = wsls_pkg::KIND_PUSH;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 70;
    requests_sent = 0;
    mismatches = 0;
    stall_cnt = 0;
    depth_cnt = 0;
    build_len = 0;
    sort_min = wsls_pkg::THR_RESET;

    // Directed table: kind, char_code, last_char, typed, expected result
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(wsls_pkg::KIND_POP,  8'hFF, 1'b1, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(wsls_pkg::KIND_PUSH, 8'h71, 1'b1, 1'b0, '0);
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b1, mk_res(8'h71, 1'b1, 1'b0, 1'b0, 1'b0));
    // five bytes at the threshold of reset: comes out sorted
    add_row(wsls_pkg::KIND_PUSH, 8'hFF, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h00, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h80, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h7F, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h01, 1'b1, 1'b0, '0);
    // partial word abandoned by the pop: every result flagged dropped
    add_row(wsls_pkg::KIND_PUSH, 8'h7A, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b0, '0);
    // four bytes, below the threshold: original order
    add_row(wsls_pkg::KIND_PUSH, 8'h64, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h63, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h62, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h61, 1'b1, 1'b0, '0);
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b0, '0);
    // partial word on an empty stack
    add_row(wsls_pkg::KIND_PUSH, 8'h6B, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b1, mk_res(8'h00, 1'b1, 1'b1, 1'b0, 1'b1));
    add_row(wsls_pkg::KIND_PUSH, 8'h55, 1'b0, 1'b0, '0);
    add_row(wsls_pkg::KIND_PUSH, 8'h55, 1'b1, 1'b0, '0);
    add_row(wsls_pkg::KIND_POP,  8'h00, 1'b0, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < directed_rows.size(); i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    for (p = 0; p < PHASES; p++) begin
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (p < 2) begin
        send_idle_pct = 24;
        recv_idle_pct = 70;
      end else if (p < 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) thr_plan[p] = TW'($urandom_range(15, 5));

      // write the threshold only once the block is quiet
      wait_quiet();
      cfg_wen   <= 1'b1;
      cfg_wdata <= thr_plan[p];
      @(posedge clk);
      cfg_wen   <= 1'b0;
      sort_min = thr_plan[p];

      // once per run: fill the stack, then overflow it
      if (p == 1) begin
        while (depth_cnt < DEP) send_word(1 + $urandom_range(1));
        send_word(2);
        send_word(1);
      end

      goal = requests_sent + PHASE_ITEMS;
      while (requests_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // well-formed word; aim often at the threshold and the word limit
          pick = $urandom_range(99);
          if (pick < 10 && sort_min > 0) wlen = sort_min;
          else if (pick < 20 && sort_min > 1) wlen = sort_min - 1;
          else if (pick < 75) wlen = $urandom_range(8, 1);
          else if (pick < 93) wlen = $urandom_range(29, 9);
          else wlen = $urandom_range(MAXW + 3, MAXW);
          send_word(wlen);
        end else if (pick < 85) begin
          pop_word();
        end else if (pick < 93) begin
          push_byte(CW'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
          // broken word: a few bytes, then a pop
          wlen = $urandom_range(4, 1);
          for (i = 0; i < wlen; i++) push_byte(CW'($urandom_range(255)), 1'b0);
          pop_word();
        end
      end
    end

    // drain: let every pending result arrive, then watch for strays
    wait_quiet();
    repeat (TAIL_CYC) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected results never arrived", expected_chars.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb_word_stack_letter_sort passed");
    end else begin
      $display("tb_word_stack_letter_sort failed");
    end
    $finish;
  end

endmodule
